// ===== hdl/fpba_pkg.sv =====
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types and codes for the fit policy block allocator: beat payloads,
// config register indexes, fit policy codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package fpba_pkg;

  localparam int IDX_FIELD_BITS  = 4;
  localparam int SIZE_FIELD_BITS = 16;
  localparam int CFG_DATA_BITS   = 5;
  localparam int CFG_INDEX_BITS  = 1;

  // config register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FIT_POLICY  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BLOCK_COUNT = 1'd1;

  // fit policy codes; the unused code behaves as first fit
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic [4:0] BLOCK_COUNT_RESET = 5'd16;

  // item kinds
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef struct packed {
    logic                       kind;
    logic [IDX_FIELD_BITS-1:0]  load_index;
    logic [SIZE_FIELD_BITS-1:0] load_size;
    logic [SIZE_FIELD_BITS-1:0] request_size;
  } alloc_in_t;

  typedef struct packed {
    logic                       granted;
    logic [IDX_FIELD_BITS-1:0]  block_number;
    logic [SIZE_FIELD_BITS-1:0] remaining_size;
  } alloc_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/fpba_ram.sv =====
// ----------------------------------------------------------------------------
// fpba_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/fit_policy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// Free-size table for memory blocks with first, best and worst fit search.
// A load beat writes one entry; a request beat scans the table and carves
// the request out of the chosen block.
// ----------------------------------------------------------------------------
//
//   channel | signals                       | direction | payload
//   --------+-------------------------------+-----------+-------------------
//   in      | in_valid / in_ready           | in        | alloc_in_t
//   out     | out_valid / out_ready         | out       | alloc_out_t
//   cfg     | cfg_we / cfg_index / cfg_data | in        | fit_policy, count
//
// A load writes its entry when accepted. A request scans at most limit
// entries (limit = block_count capped at MAX_BLOCKS): one table read per
// cycle through the single RAM read port, then a write-back state; first
// fit stops at the first fitting entry, and a refused request skips the
// write-back. No clearing pass after reset. The result sits in an output
// register, and in_ready rises again once it is loaded there.
// ----------------------------------------------------------------------------
`default_nettype none

module fit_policy_block_allocator
  import fpba_pkg::*;
#(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire alloc_in_t                 in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output alloc_out_t                     out_data,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  state_t                 state, state_next;
  logic [1:0]             fit_policy;
  logic [4:0]             block_count;
  logic [CNT_W-1:0]       limit;

  logic [SIZE_BITS-1:0]   req, req_next;
  logic [IDX_W-1:0]       scan_idx, scan_idx_next;
  logic                   found, found_next;
  logic [IDX_W-1:0]       pick, pick_next;
  logic [SIZE_BITS-1:0]   pick_val, pick_val_next;
  alloc_out_t             res, res_next;
  alloc_out_t             out_data_next;
  logic                   out_valid_next;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [SIZE_BITS-1:0]   ram_wdata;
  logic [IDX_W-1:0]       ram_raddr;
  logic [SIZE_BITS-1:0]   ram_rdata;

  logic                   in_fire;
  logic                   load_ok;
  logic                   fits;
  logic                   scan_last;
  logic                   first_like;
  logic [SIZE_BITS-1:0]   left;

  fpba_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy  <= FIT_FIRST;
      block_count <= BLOCK_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIT_POLICY:  fit_policy  <= cfg_data[1:0];
        CFG_BLOCK_COUNT: block_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(block_count) > MAX_BLOCKS) begin
      limit = CNT_W'(MAX_BLOCKS);
    end else begin
      limit = CNT_W'(block_count);
    end
  end

  assign in_ready   = (state == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign load_ok    = int'(in_data.load_index) < MAX_BLOCKS;
  assign first_like = (fit_policy != FIT_BEST) && (fit_policy != FIT_WORST);
  assign fits       = ram_rdata >= req;
  assign scan_last  = (CNT_W'(scan_idx) + CNT_W'(1)) == limit;
  // the one subtractor, used in the write-back cycle
  assign left       = pick_val - req;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    req      <= req_next;
    scan_idx <= scan_idx_next;
    found    <= found_next;
    pick     <= pick_next;
    pick_val <= pick_val_next;
    res      <= res_next;
    out_data <= out_data_next;
  end

  always_comb begin
    state_next     = state;
    req_next       = req;
    scan_idx_next  = scan_idx;
    found_next     = found;
    pick_next      = pick;
    pick_val_next  = pick_val;
    res_next       = res;
    out_data_next  = out_data;
    out_valid_next = out_valid && !out_ready;
    ram_we         = 1'b0;
    ram_waddr      = IDX_W'(in_data.load_index);
    ram_wdata      = SIZE_BITS'(in_data.load_size);
    ram_raddr      = '0;

    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.kind == KIND_LOAD) begin
            ram_we                  = load_ok;
            res_next.granted        = load_ok;
            res_next.block_number   = in_data.load_index;
            res_next.remaining_size = load_ok ?
              SIZE_FIELD_BITS'(SIZE_BITS'(in_data.load_size)) : '0;
            state_next              = ST_RESULT;
          end else begin
            // entry 0 is read now and shows up at the start of the scan
            req_next       = SIZE_BITS'(in_data.request_size);
            scan_idx_next  = '0;
            found_next     = 1'b0;
            pick_next      = '0;
            pick_val_next  = '0;
            res_next       = '0;
            state_next     = (limit == '0) ? ST_RESULT : ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        ram_raddr     = scan_idx + IDX_W'(1);
        scan_idx_next = scan_idx + IDX_W'(1);
        if (fits) begin
          if (!found) begin
            found_next    = 1'b1;
            pick_next     = scan_idx;
            pick_val_next = ram_rdata;
          end else if (fit_policy == FIT_BEST && ram_rdata < pick_val) begin
            pick_next     = scan_idx;
            pick_val_next = ram_rdata;
          end else if (fit_policy == FIT_WORST && ram_rdata > pick_val) begin
            pick_next     = scan_idx;
            pick_val_next = ram_rdata;
          end
        end
        if (scan_last || (first_like && fits)) begin
          state_next = found_next ? ST_WRITE : ST_RESULT;
        end
      end

      ST_WRITE: begin
        ram_we                  = 1'b1;
        ram_waddr               = pick;
        ram_wdata               = left;
        res_next.granted        = 1'b1;
        res_next.block_number   = IDX_FIELD_BITS'(pick);
        res_next.remaining_size = SIZE_FIELD_BITS'(left);
        state_next              = ST_RESULT;
      end

      ST_RESULT: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          out_data_next  = res;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // the write-back never underflows
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    state == ST_WRITE |-> pick_val >= req)
    else $error("write-back below request size");

  // the scan never runs past the searched range
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> CNT_W'(scan_idx) < limit)
    else $error("scan index past block count");

  // a load to a real entry always reports granted
  a_load_granted: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_data.kind == KIND_LOAD && load_ok
      |=> state == ST_RESULT && res.granted)
    else $error("load in range not granted");

  // a write-back always follows a pick inside the searched range
  a_pick_fits: assert property (@(posedge clk) disable iff (rst)
    state == ST_WRITE |-> found && CNT_W'(pick) < limit)
    else $error("write-back without a valid pick");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fit policy block allocator. Loads the free-size
// table, runs directed first, best and worst fit requests and register edge
// values, then random load/request traffic over several policy and count
// settings. A local model of the table predicts every result beat; random
// gaps and output holds exercise the valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import fpba_pkg::*;

  localparam int NUM_ENTRIES   = 16;
  localparam int LIMIT_CYCLES  = 600000;
  localparam int HOLD_CYCLES   = 300;
  localparam int TAIL_CYCLES   = 25;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 106;
  localparam logic [1:0] FIT_UNUSED = 2'd3;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  alloc_in_t  in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  alloc_out_t out_data;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  // local copy of the allocator state
  logic [SIZE_FIELD_BITS-1:0] free_size [NUM_ENTRIES];
  logic [1:0]                 fit_rule = FIT_FIRST;
  logic [4:0]                 search_count = BLOCK_COUNT_RESET;

  alloc_out_t pending_results [$];
  alloc_out_t result_want;

  int errors = 0;
  int cycle_count = 0;
  int n_loads = 0;
  int n_granted = 0;
  int n_refused = 0;
  bit idle_on = 1'b1;

  // receiver hold-off handshake between the test and the ready driver
  int hold_trigger = 0;
  int hold_seen = 0;
  int rx_hold = 0;
  int rx_stall = 0;

  fit_policy_block_allocator dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles, %0d results pending", $time, cycle_count,
               pending_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // expected result of one beat; updates the local table
  function automatic alloc_out_t alloc_result(input alloc_in_t it);
    alloc_out_t r;
    int limit;
    bit found;
    bit stop;
    logic [IDX_FIELD_BITS-1:0] pick;
    r = '0;
    if (it.kind == KIND_LOAD) begin
      free_size[it.load_index] = it.load_size;
      r.granted = 1'b1;
      r.block_number = it.load_index;
      r.remaining_size = it.load_size;
      return r;
    end
    limit = (search_count > NUM_ENTRIES) ? NUM_ENTRIES : int'(search_count);
    found = 1'b0;
    stop = 1'b0;
    pick = '0;
    for (int j = 0; j < limit; j++) begin
      if (!stop && free_size[j] >= it.request_size) begin
        if (!found) begin
          found = 1'b1;
          pick = IDX_FIELD_BITS'(j);
          // first fit and the unused code stop at the first hit
          if (fit_rule != FIT_BEST && fit_rule != FIT_WORST) stop = 1'b1;
        end else if (fit_rule == FIT_BEST && free_size[j] < free_size[pick]) begin
          pick = IDX_FIELD_BITS'(j);
        end else if (fit_rule == FIT_WORST && free_size[j] > free_size[pick]) begin
          pick = IDX_FIELD_BITS'(j);
        end
      end
    end
    if (!found) return r;
    free_size[pick] = free_size[pick] - it.request_size;
    r.granted = 1'b1;
    r.block_number = pick;
    r.remaining_size = free_size[pick];
    return r;
  endfunction

  function automatic alloc_in_t load_beat(input int idx, input int size);
    alloc_in_t r;
    r.kind = KIND_LOAD;
    r.load_index = IDX_FIELD_BITS'(idx);
    r.load_size = SIZE_FIELD_BITS'(size);
    r.request_size = SIZE_FIELD_BITS'($urandom);
    return r;
  endfunction

  function automatic alloc_in_t request_beat(input int size);
    alloc_in_t r;
    r.kind = KIND_REQUEST;
    r.load_index = IDX_FIELD_BITS'($urandom);
    r.load_size = SIZE_FIELD_BITS'($urandom);
    r.request_size = SIZE_FIELD_BITS'(size);
    return r;
  endfunction

  function automatic int rand_load_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom_range(0, 4095);
    if (r < 85) return $urandom_range(0, 65535);
    if (r < 92) return 0;
    return 65535;
  endfunction

  function automatic int rand_request_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom_range(0, 255);
    if (r < 75) return $urandom_range(0, 4095);
    if (r < 90) return $urandom_range(0, 65535);
    if (r < 95) return 0;
    return 65535;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_item(input alloc_in_t item);
    int gap;
    alloc_out_t want;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = item;
    do @(posedge clk); while (!in_ready);
    want = alloc_result(item);
    pending_results.push_back(want);
    if (item.kind == KIND_LOAD) n_loads++;
    else if (want.granted) n_granted++;
    else n_refused++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_FIT_POLICY) fit_rule = val[1:0];
    else search_count = val;
  endtask

  task automatic set_search(input logic [1:0] policy, input int count);
    wait_drained();
    write_reg(CFG_FIT_POLICY, CFG_DATA_BITS'(policy));
    write_reg(CFG_BLOCK_COUNT, CFG_DATA_BITS'(count));
  endtask

  // every entry is loaded before any request can read it
  task automatic test_load_table();
    int sizes [NUM_ENTRIES];
    sizes = '{0, 65535, 100, 50, 50, 300, 32768, 32767,
              1, 300, 2000, 50, 65534, 10, 999, 21845};
    for (int i = 0; i < NUM_ENTRIES; i++) send_item(load_beat(i, sizes[i]));
  endtask

  task automatic test_first_fit();
    set_search(FIT_FIRST, NUM_ENTRIES);
    send_item(request_beat(0));
    send_item(request_beat(60));
    send_item(request_beat(65535));
  endtask

  task automatic test_best_fit();
    set_search(FIT_BEST, NUM_ENTRIES);
    send_item(request_beat(50));
    send_item(request_beat(300));
  endtask

  task automatic test_worst_fit();
    set_search(FIT_WORST, NUM_ENTRIES);
    send_item(request_beat(1));
    send_item(request_beat(65534));
  endtask

  task automatic test_register_edges();
    set_search(FIT_FIRST, 0);
    send_item(request_beat(0));
    set_search(FIT_WORST, 1);
    send_item(request_beat(0));
    set_search(FIT_UNUSED, 31);
    send_item(request_beat(1));
    set_search(FIT_BEST, 31);
    send_item(request_beat(40000));
  endtask

  // receiver stops while the sender keeps offering beats
  task automatic test_output_backpressure();
    set_search(FIT_FIRST, NUM_ENTRIES);
    idle_on = 1'b0;
    hold_trigger++;
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 0) send_item(load_beat($urandom_range(0, 15), rand_load_size()));
      else send_item(request_beat(rand_request_size()));
    end
    wait_drained();
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [1:0] pol_set [6];
    int cnt_set [6];
    logic [1:0] pol;
    int cnt;
    pol_set = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_UNUSED, FIT_BEST, FIT_WORST};
    cnt_set = '{16, 1, 31, 7, 16, 0};
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 6) begin
        pol = pol_set[p];
        cnt = cnt_set[p];
      end else begin
        pol = 2'($urandom_range(0, 3));
        cnt = $urandom_range(1, 31);
      end
      set_search(pol, cnt);
      idle_on = (p % 3 != 1);
      // the zero count phase refuses every request, keep it short
      for (int i = 0; i < ((cnt == 0) ? 20 : PHASE_ITEMS); i++) begin
        if ($urandom_range(0, 99) < 28)
          send_item(load_beat($urandom_range(0, 15), rand_load_size()));
        else
          send_item(request_beat(rand_request_size()));
      end
      if (p == 4) hold_trigger++;
    end
    idle_on = 1'b1;
  endtask

  // result side ready with random stalls and long holds
  always @(negedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen = hold_trigger;
      rx_hold = HOLD_CYCLES;
    end
    if (rx_hold > 0) begin
      out_ready = 1'b0;
      rx_hold--;
    end else if (rx_stall > 0) begin
      out_ready = 1'b0;
      rx_stall--;
    end else begin
      out_ready = 1'b1;
      if ($urandom_range(0, 99) < 25) rx_stall = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat granted %0b block %0d remaining %0d", $time,
                 out_data.granted, out_data.block_number, out_data.remaining_size);
        errors++;
      end else begin
        result_want = pending_results.pop_front();
        if (out_data !== result_want) begin
          $display("%0t: mismatch exp granted %0b block %0d remaining %0d, got %0b %0d %0d",
                   $time, result_want.granted, result_want.block_number,
                   result_want.remaining_size, out_data.granted, out_data.block_number,
                   out_data.remaining_size);
          errors++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    repeat (7) @(negedge clk);
    rst = 1'b0;
    test_load_table();
    test_first_fit();
    test_best_fit();
    test_worst_fit();
    test_register_edges();
    test_output_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("covered %0d loads, %0d granted and %0d refused requests", n_loads, n_granted,
             n_refused);
    $display("first, best, worst and unused fit codes; block counts 0, 1, 7, 16 and 31");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== fit_policy_block_allocator.f =====
hdl/fpba_pkg.sv
hdl/fpba_ram.sv
hdl/fit_policy_block_allocator.sv
tb/sv/tb_top.sv
